// File: sv/phd_pkg.sv
// ----------------------------------------------------------------------------
// phd_pkg: shared types and constants of the piezo hit peak detector
// Holds the phase encoding, register indexes, register file and state structs.
// ----------------------------------------------------------------------------
package phd_pkg;

  // Phase of the hit machine; code 3 is never entered and decodes as idle
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_CAPTURE  = 2'd1,
    PH_COOLDOWN = 2'd2
  } phase_t;

  localparam int THR_W     = 12;
  localparam int TIME_W    = 32;
  localparam int VEL_W     = 7;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W     = 16;

  localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;
  localparam logic [VEL_W-1:0] VEL_LOW = 7'd1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_THR  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REARM_THR    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCAN_WINDOW  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COOLDOWN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FIXED_MODE   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FIXED_VEL    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_GAIN     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_VEL      = 3'd7;

  typedef struct packed {
    logic [THR_W-1:0]  trigger_threshold;
    logic [THR_W-1:0]  rearm_threshold;
    logic [TIME_W-1:0] scan_window_us;
    logic [TIME_W-1:0] cooldown_ms;
    logic              fixed_velocity_mode;
    logic [VEL_W-1:0]  fixed_velocity;
    logic [GAIN_W-1:0] velocity_gain;
    logic [VEL_W-1:0]  min_velocity;
  } cfg_t;

  // Machine state apart from the sample-wide peak level
  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] scan_start_us;
    logic [TIME_W-1:0] last_hit_ms;
    logic [VEL_W-1:0]  held_velocity;
  } state_t;

endpackage

// File: sv/piezo_hit_peak_detector_unit.sv
// ----------------------------------------------------------------------------
// piezo_hit_peak_detector_unit: drum trigger peak detector with retrigger mask
// One result transaction per sample transaction: hit flag, held velocity, phase.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  in_      | slave     | in_tvalid/in_tready  | sample, time_us, time_ms
//  out_     | master    | out_tvalid/out_tready| hit, velocity, phase
//  cfg_     | write     | cfg_we               | cfg_addr selects, cfg_wdata value
//
//  Each sample passes the input register, then the step logic into the result
//  register. Sustained rate is one sample per cycle while out_tready stays
//  high; the state loop of the phase machine (compare, one 16-bit multiply,
//  clamp), closed through the state register, sets that figure.
//  rst_n is synchronous: both stages empty, state cleared, registers back at
//  their defaults. A stalled result holds while the input register still takes
//  one more sample; the input stalls only when both stages are full.
//
module piezo_hit_peak_detector_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata fields, lowest bit up: sample, time_us, time_ms, zero padding
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+2*phd_pkg::TIME_W+7)/8)*8-1:0] in_tdata,
  // out_tdata fields, lowest bit up: hit, velocity[6:0], phase[1:0], zero padding
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [phd_pkg::OUT_W-1:0]         out_tdata,
  input  logic                              cfg_we,
  input  logic [phd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [phd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int TW    = phd_pkg::TIME_W;
  localparam int US_LO = SAMPLE_BITS;
  localparam int MS_LO = SAMPLE_BITS + TW;

  phd_pkg::cfg_t cfg;

  // Input stage
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [TW-1:0]          time_us_r;
  logic [TW-1:0]          time_ms_r;

  // Result stage
  logic                   out_valid_r;
  logic [phd_pkg::OUT_W-1:0] out_data_r;
  logic [phd_pkg::OUT_W-1:0] out_data_nxt;

  // Machine state
  phd_pkg::state_t        st_r;
  phd_pkg::state_t        st_nxt;
  logic [SAMPLE_BITS-1:0] peak_r;
  logic [SAMPLE_BITS-1:0] peak_nxt;
  logic                   hit_nxt;

  logic                   advance;

  phd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  phd_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .cfg      (cfg),
    .st       (st_r),
    .peak     (peak_r),
    .sample   (sample_r),
    .time_us  (time_us_r),
    .time_ms  (time_ms_r),
    .st_nxt   (st_nxt),
    .peak_nxt (peak_nxt),
    .hit      (hit_nxt)
  );

  // Advance the held sample into the result register when it is free or drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      sample_r  <= in_tdata[SAMPLE_BITS-1:0];
      time_us_r <= in_tdata[US_LO+TW-1:US_LO];
      time_ms_r <= in_tdata[MS_LO+TW-1:MS_LO];
    end
  end

  // Commit the machine state exactly once per sample, as it moves to the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= phd_pkg::PH_IDLE;
      st_r.scan_start_us <= '0;
      st_r.last_hit_ms   <= '0;
      st_r.held_velocity <= '0;
      peak_r             <= '0;
    end else if (advance) begin
      st_r   <= st_nxt;
      peak_r <= peak_nxt;
    end
  end

  always_comb begin
    out_data_nxt       = '0;
    out_data_nxt[0]    = hit_nxt;
    out_data_nxt[7:1]  = st_nxt.held_velocity;
    out_data_nxt[9:8]  = st_nxt.phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/phd_cfg_regs.sv
// ----------------------------------------------------------------------------
// phd_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port, reset to defaults.
// ----------------------------------------------------------------------------
module phd_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [phd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [phd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output phd_pkg::cfg_t                        cfg
);

  phd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_threshold   <= 12'd200;
      cfg_r.rearm_threshold     <= 12'd100;
      cfg_r.scan_window_us      <= 32'd2000;
      cfg_r.cooldown_ms         <= 32'd30;
      cfg_r.fixed_velocity_mode <= 1'b0;
      cfg_r.fixed_velocity      <= 7'd100;
      cfg_r.velocity_gain       <= 16'd3049;
      cfg_r.min_velocity        <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        phd_pkg::REG_TRIGGER_THR: cfg_r.trigger_threshold <= cfg_wdata[phd_pkg::THR_W-1:0];
        phd_pkg::REG_REARM_THR:   cfg_r.rearm_threshold   <= cfg_wdata[phd_pkg::THR_W-1:0];
        phd_pkg::REG_SCAN_WINDOW: cfg_r.scan_window_us    <= cfg_wdata[phd_pkg::TIME_W-1:0];
        phd_pkg::REG_COOLDOWN:    cfg_r.cooldown_ms       <= cfg_wdata[phd_pkg::TIME_W-1:0];
        phd_pkg::REG_FIXED_MODE:  cfg_r.fixed_velocity_mode <= cfg_wdata[0];
        phd_pkg::REG_FIXED_VEL:   cfg_r.fixed_velocity    <= cfg_wdata[phd_pkg::VEL_W-1:0];
        phd_pkg::REG_VEL_GAIN:    cfg_r.velocity_gain     <= cfg_wdata[phd_pkg::GAIN_W-1:0];
        phd_pkg::REG_MIN_VEL:     cfg_r.min_velocity      <= cfg_wdata[phd_pkg::VEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/phd_core.sv
// ----------------------------------------------------------------------------
// phd_core: next-state and velocity logic for one sample
// Pure combinational step of the idle / capture / cooldown machine.
// ----------------------------------------------------------------------------
module phd_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  phd_pkg::cfg_t                  cfg,
  input  phd_pkg::state_t                st,
  input  logic [SAMPLE_BITS-1:0]         peak,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [phd_pkg::TIME_W-1:0]     time_us,
  input  logic [phd_pkg::TIME_W-1:0]     time_ms,
  output phd_pkg::state_t                st_nxt,
  output logic [SAMPLE_BITS-1:0]         peak_nxt,
  output logic                           hit
);

  localparam int CMP_W  = (SAMPLE_BITS > phd_pkg::THR_W) ? SAMPLE_BITS : phd_pkg::THR_W;
  localparam int PROD_W = SAMPLE_BITS + phd_pkg::GAIN_W;

  logic [SAMPLE_BITS-1:0]     peak_max;
  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_BITS-1:0]     vel_raw;
  logic [SAMPLE_BITS-1:0]     vel_min;
  logic [phd_pkg::VEL_W-1:0]  vel_calc;
  logic                       above_trig;
  logic                       below_rearm;
  logic                       us_elapsed;
  logic                       ms_elapsed;
  logic [phd_pkg::TIME_W-1:0] us_delta;
  logic [phd_pkg::TIME_W-1:0] ms_delta;

  assign peak_max    = (sample > peak) ? sample : peak;
  assign above_trig  = CMP_W'(sample) > CMP_W'(cfg.trigger_threshold);
  assign below_rearm = CMP_W'(sample) < CMP_W'(cfg.rearm_threshold);
  assign us_delta    = time_us - st.scan_start_us;
  assign ms_delta    = time_ms - st.last_hit_ms;
  assign us_elapsed  = us_delta >= cfg.scan_window_us;
  assign ms_elapsed  = ms_delta >= cfg.cooldown_ms;

  // Scale the captured peak, drop the fraction, clamp to [min, max]
  assign prod    = PROD_W'(peak_max) * PROD_W'(cfg.velocity_gain);
  assign vel_raw = prod[PROD_W-1:phd_pkg::GAIN_FRAC];
  assign vel_min = (vel_raw < SAMPLE_BITS'(cfg.min_velocity)) ?
                   SAMPLE_BITS'(cfg.min_velocity) : vel_raw;

  always_comb begin
    if (CMP_W'(peak_max) <= CMP_W'(cfg.trigger_threshold)) begin
      vel_calc = phd_pkg::VEL_LOW;
    end else if (vel_min > SAMPLE_BITS'(phd_pkg::VEL_MAX)) begin
      vel_calc = phd_pkg::VEL_MAX;
    end else begin
      vel_calc = vel_min[phd_pkg::VEL_W-1:0];
    end
  end

  always_comb begin
    st_nxt   = st;
    peak_nxt = peak;
    hit      = 1'b0;
    case (st.phase)
      phd_pkg::PH_CAPTURE: begin
        peak_nxt = peak_max;
        if (us_elapsed) begin
          st_nxt.held_velocity = vel_calc;
          st_nxt.last_hit_ms   = time_ms;
          st_nxt.phase         = phd_pkg::PH_COOLDOWN;
          hit                  = 1'b1;
        end
      end
      phd_pkg::PH_COOLDOWN: begin
        if (ms_elapsed && below_rearm) begin
          st_nxt.phase = phd_pkg::PH_IDLE;
        end
      end
      default: begin
        st_nxt.phase = phd_pkg::PH_IDLE;
        if (above_trig) begin
          if (cfg.fixed_velocity_mode) begin
            st_nxt.held_velocity = cfg.fixed_velocity;
            st_nxt.last_hit_ms   = time_ms;
            st_nxt.phase         = phd_pkg::PH_COOLDOWN;
            hit                  = 1'b1;
          end else begin
            peak_nxt             = sample;
            st_nxt.scan_start_us = time_us;
            st_nxt.phase         = phd_pkg::PH_CAPTURE;
          end
        end
      end
    endcase
  end

endmodule

// File: sv/phd_checker.sv
// ----------------------------------------------------------------------------
// phd_checker: port-level assertions for the peak detector
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module phd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [phd_pkg::OUT_W-1:0] out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A hit always leaves the machine in cooldown
  a_hit_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[9:8] == phd_pkg::PH_COOLDOWN)
    else $error("hit reported outside cooldown");

  // An empty result stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result stage");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind piezo_hit_peak_detector_unit phd_checker u_phd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
